// ----- hdl/tapr_pkg.sv -----
// Shared types and constants for the threshold alarm PWM ramp core.
// No dependencies.
`default_nettype none

package tapr_pkg;

  localparam int SAMPLE_W = 12;
  localparam int TEMP_LIMIT_W = 11;
  localparam int HUM_LIMIT_W = 10;
  localparam int INTERVAL_W = 10;
  localparam int HOLD_W = 16;
  localparam int INCR_W = 8;
  localparam int ELAPSED_W = 16;
  localparam int DUTY_OUT_W = 8;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DUTY_MAX_DEF = 255;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  localparam sample_t TEMP_MIN = -12'sd400;
  localparam sample_t TEMP_MAX = 12'sd800;
  localparam sample_t HUM_MIN = 12'sd0;
  localparam sample_t HUM_MAX = 12'sd1000;

  localparam logic signed [TEMP_LIMIT_W-1:0] TEMP_LIMIT_RST = 11'sd300;
  localparam logic [HUM_LIMIT_W-1:0] HUM_LIMIT_RST = 10'd800;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 10'd50;
  localparam logic [HOLD_W-1:0] HOLD_RST = 16'd3000;
  localparam logic [INCR_W-1:0] INCR_RST = 8'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_LIMIT = 3'd0,
    CFG_HUM_LIMIT  = 3'd1,
    CFG_INTERVAL   = 3'd2,
    CFG_HOLD       = 3'd3,
    CFG_INCR       = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic    action;
    sample_t temperature;
    sample_t humidity;
  } req_word_t;

  typedef struct packed {
    logic [DUTY_OUT_W-1:0] duty;
    logic                  alarm_on;
    logic                  sample_ok;
    logic                  display_changed;
  } rsp_word_t;

endpackage

`default_nettype wire

// ----- hdl/tapr_req_if.sv -----
// Input channel: sample or tick words, valid/ready handshake.
// Depends on tapr_pkg.
`default_nettype none

interface tapr_req_if
  import tapr_pkg::*;
();
  logic    valid;
  logic    ready;
  logic    action;
  sample_t temperature;
  sample_t humidity;

  modport source (output valid, output action, output temperature, output humidity,
                  input ready);
  modport sink (input valid, input action, input temperature, input humidity,
                output ready);
endinterface

`default_nettype wire

// ----- hdl/tapr_rsp_if.sv -----
// Result channel: duty and status words, valid/ready handshake.
// Depends on tapr_pkg.
`default_nettype none

interface tapr_rsp_if
  import tapr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [DUTY_OUT_W-1:0] duty;
  logic                  alarm_on;
  logic                  sample_ok;
  logic                  display_changed;

  modport source (output valid, output duty, output alarm_on, output sample_ok,
                  output display_changed, input ready);
  modport sink (input valid, input duty, input alarm_on, input sample_ok,
                input display_changed, output ready);
endinterface

`default_nettype wire

// ----- hdl/threshold_alarm_pwm_ramp_core.sv -----
// Threshold alarm with PWM duty ramp, hold and switch-off.
// Throughput: one word per cycle while the result channel is not stalled; input register,
// one pass of compares and adds on the alarm state, then the result register.
// Reset (rst, synchronous): config registers to defaults, alarm idle, duty 0,
// previous sample 0, both pipeline registers empty.
// Depends on tapr_pkg, tapr_req_if, tapr_rsp_if.
`default_nettype none

module threshold_alarm_pwm_ramp_core
  import tapr_pkg::*;
#(
  parameter int DUTY_MAX = DUTY_MAX_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  tapr_req_if.sink                   req,
  tapr_rsp_if.source                 rsp,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DUTY_W = $clog2(DUTY_MAX + 1);
  localparam int SUM_W = ((DUTY_W > INCR_W) ? DUTY_W : INCR_W) + 1;
  localparam logic [DUTY_W-1:0] DUTY_TOP = DUTY_W'(DUTY_MAX);
  localparam logic [SUM_W-1:0] DUTY_TOP_X = SUM_W'(DUTY_MAX);

  // config
  logic signed [TEMP_LIMIT_W-1:0] temp_limit;
  logic [HUM_LIMIT_W-1:0]         humidity_limit;
  logic [INTERVAL_W-1:0]          ramp_interval;
  logic [HOLD_W-1:0]              hold_time;
  logic [INCR_W-1:0]              duty_increment;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_limit     <= TEMP_LIMIT_RST;
      humidity_limit <= HUM_LIMIT_RST;
      ramp_interval  <= INTERVAL_RST;
      hold_time      <= HOLD_RST;
      duty_increment <= INCR_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TEMP_LIMIT: temp_limit     <= cfg_data[TEMP_LIMIT_W-1:0];
        CFG_HUM_LIMIT:  humidity_limit <= cfg_data[HUM_LIMIT_W-1:0];
        CFG_INTERVAL:   ramp_interval  <= cfg_data[INTERVAL_W-1:0];
        CFG_HOLD:       hold_time      <= cfg_data[HOLD_W-1:0];
        CFG_INCR:       duty_increment <= cfg_data[INCR_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic      in_valid;
  req_word_t in_word;
  logic      advance;

  assign advance   = in_valid && (!rsp.valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_word.action      <= req.action;
      in_word.temperature <= req.temperature;
      in_word.humidity    <= req.humidity;
    end
  end

  // alarm state
  logic                 active, active_next;
  logic                 holding, holding_next;
  logic [DUTY_W-1:0]    duty_level, duty_level_next;
  logic [ELAPSED_W-1:0] elapsed, elapsed_next;
  sample_t              prev_temperature, prev_temperature_next;
  sample_t              prev_humidity, prev_humidity_next;

  logic                 ok, changed, trigger;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [SUM_W-1:0]     duty_sum;
  logic [SUM_W-1:0]     duty_wide;
  rsp_word_t            rsp_next;

  always_comb begin
    active_next           = active;
    holding_next          = holding;
    duty_level_next       = duty_level;
    elapsed_next          = elapsed;
    prev_temperature_next = prev_temperature;
    prev_humidity_next    = prev_humidity;

    ok = !in_word.action
         && (in_word.temperature >= TEMP_MIN) && (in_word.temperature <= TEMP_MAX)
         && (in_word.humidity >= HUM_MIN) && (in_word.humidity <= HUM_MAX);
    changed = ok && ((in_word.temperature != prev_temperature)
                     || (in_word.humidity != prev_humidity));
    // humidity is non-negative whenever ok is set
    trigger = ok && ((in_word.temperature > SAMPLE_W'(temp_limit))
                     || (in_word.humidity > $signed({2'b00, humidity_limit})));

    elapsed_inc = (elapsed == {ELAPSED_W{1'b1}}) ? elapsed : elapsed + 1'b1;
    duty_sum    = SUM_W'(duty_level) + SUM_W'(duty_increment);

    if (!in_word.action) begin
      if (changed) begin
        prev_temperature_next = in_word.temperature;
        prev_humidity_next    = in_word.humidity;
      end
      if (trigger) begin
        active_next     = 1'b1;
        holding_next    = 1'b0;
        duty_level_next = '0;
        elapsed_next    = '0;
      end
    end else if (active) begin
      if (!holding) begin
        if (duty_level < DUTY_TOP) begin
          if (elapsed_inc >= ELAPSED_W'(ramp_interval)) begin
            duty_level_next = (duty_sum > DUTY_TOP_X) ? DUTY_TOP : duty_sum[DUTY_W-1:0];
            elapsed_next    = '0;
          end else begin
            elapsed_next = elapsed_inc;
          end
        end else begin
          holding_next = 1'b1;
          elapsed_next = '0;
        end
      end else begin
        elapsed_next = elapsed_inc;
        if (elapsed_inc >= hold_time) begin
          active_next     = 1'b0;
          holding_next    = 1'b0;
          duty_level_next = '0;
        end
      end
    end

    duty_wide                = SUM_W'(duty_level_next);
    rsp_next.duty            = duty_wide[DUTY_OUT_W-1:0];
    rsp_next.alarm_on        = active_next;
    rsp_next.sample_ok       = ok;
    rsp_next.display_changed = changed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active           <= 1'b0;
      holding          <= 1'b0;
      duty_level       <= '0;
      elapsed          <= '0;
      prev_temperature <= '0;
      prev_humidity    <= '0;
    end else if (advance) begin
      active           <= active_next;
      holding          <= holding_next;
      duty_level       <= duty_level_next;
      elapsed          <= elapsed_next;
      prev_temperature <= prev_temperature_next;
      prev_humidity    <= prev_humidity_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.duty            <= rsp_next.duty;
      rsp.alarm_on        <= rsp_next.alarm_on;
      rsp.sample_ok       <= rsp_next.sample_ok;
      rsp.display_changed <= rsp_next.display_changed;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for threshold_alarm_pwm_ramp_core: directed and random
// sample/tick words, an internal alarm predictor, random stalls on both channels.
// Depends on tapr_pkg, tapr_req_if, tapr_rsp_if and the core.
`timescale 1ns / 1ps

module tb_top;
  import tapr_pkg::*;

  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_TICK = 1'b1;
  localparam int DRAIN_CYCLES = 4;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_TEMP_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic sink_ready = 1'b0;

  tapr_req_if req_ch();
  tapr_rsp_if rsp_ch();

  assign rsp_ch.ready = sink_ready;

  threshold_alarm_pwm_ramp_core DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // alarm predictor state and register copies
  int lim_temp, lim_hum, ramp_iv, hold_len, duty_step;
  bit alarm_act, alarm_hold;
  int duty_lvl, ticks;
  int last_temp, last_hum;

  rsp_word_t expected_q[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left = 0;
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int alarm_starts = 0;
  int reg_writes = 0;

  function automatic int clip(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic rsp_word_t alarm_next(req_word_t w);
    rsp_word_t r;
    int t, h;
    r = '0;
    t = int'($signed(w.temperature));
    h = int'($signed(w.humidity));
    if (w.action == ACT_SAMPLE) begin
      if (t >= TEMP_MIN && t <= TEMP_MAX && h >= HUM_MIN && h <= HUM_MAX) begin
        r.sample_ok = 1'b1;
        if (t != last_temp || h != last_hum) begin
          r.display_changed = 1'b1;
          last_temp = t;
          last_hum = h;
        end
        if (t > lim_temp || h > lim_hum) begin
          alarm_act = 1'b1;
          alarm_hold = 1'b0;
          duty_lvl = 0;
          ticks = 0;
          alarm_starts++;
        end
      end
    end else if (alarm_act) begin
      if (!alarm_hold) begin
        if (duty_lvl < DUTY_MAX_DEF) begin
          if (ticks < 65535) ticks++;
          if (ticks >= ramp_iv) begin
            duty_lvl = clip(duty_lvl + duty_step, 0, DUTY_MAX_DEF);
            ticks = 0;
          end
        end else begin
          alarm_hold = 1'b1;
          ticks = 0;
        end
      end else begin
        if (ticks < 65535) ticks++;
        if (ticks >= hold_len) begin
          alarm_act = 1'b0;
          alarm_hold = 1'b0;
          duty_lvl = 0;
        end
      end
    end
    r.duty = duty_lvl[DUTY_OUT_W-1:0];
    r.alarm_on = alarm_act;
    return r;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_word();
    rsp_word_t want;
    if (expected_q.size() == 0) begin
      report("word with nothing pending", rsp_ch.duty, 0);
      return;
    end
    want = expected_q.pop_front();
    words_checked++;
    if (rsp_ch.duty !== want.duty) report("duty", rsp_ch.duty, want.duty);
    if (rsp_ch.alarm_on !== want.alarm_on) report("alarm_on", rsp_ch.alarm_on, want.alarm_on);
    if (rsp_ch.sample_ok !== want.sample_ok)
      report("sample_ok", rsp_ch.sample_ok, want.sample_ok);
    if (rsp_ch.display_changed !== want.display_changed)
      report("display_changed", rsp_ch.display_changed, want.display_changed);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) check_word();
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // all tasks below start and end just after a falling edge
  task automatic send_word(input logic act, input int t, input int h);
    req_word_t w;
    w.action = act;
    w.temperature = sample_t'(t);
    w.humidity = sample_t'(h);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.action = w.action;
    req_ch.temperature = w.temperature;
    req_ch.humidity = w.humidity;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_q.push_back(alarm_next(w));
    words_sent++;
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_word(ACT_TICK, 0, 0);
  endtask

  task automatic settle();
    req_ch.valid = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we = 1'b0;
    reg_writes++;
    case (idx)
      CFG_TEMP_LIMIT: lim_temp = int'($signed(val[TEMP_LIMIT_W-1:0]));
      CFG_HUM_LIMIT:  lim_hum = val[HUM_LIMIT_W-1:0];
      CFG_INTERVAL:   ramp_iv = val[INTERVAL_W-1:0];
      CFG_HOLD:       hold_len = val[HOLD_W-1:0];
      CFG_INCR:       duty_step = val[INCR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input int t, input int h, input int iv, input int hd, input int inc);
    settle();
    write_reg(CFG_TEMP_LIMIT, t);
    write_reg(CFG_HUM_LIMIT, h);
    write_reg(CFG_INTERVAL, iv);
    write_reg(CFG_HOLD, hd);
    write_reg(CFG_INCR, inc);
  endtask

  task automatic send_random_word();
    int pick, t, h;
    pick = $urandom_range(99);
    t = $urandom_range(1200) - 400;
    h = $urandom_range(1000);
    if (pick < 68) begin
      send_word(ACT_TICK, $urandom, $urandom);
      return;
    end
    if (pick < 80) begin
      t = clip(lim_temp + int'($urandom_range(8)) - 4, TEMP_MIN, TEMP_MAX);
      h = $urandom_range(lim_hum);
    end else if (pick < 88) begin
      h = clip(lim_hum + int'($urandom_range(8)) - 4, HUM_MIN, HUM_MAX);
      t = clip(lim_temp - int'($urandom_range(50)), TEMP_MIN, TEMP_MAX);
    end else if (pick < 93) begin
      t = last_temp;
      h = last_hum;
    end else begin
      t = $urandom;
      h = $urandom;
    end
    send_word(ACT_SAMPLE, t, h);
  endtask

  task automatic test_thresholds();
    send_word(ACT_SAMPLE, 0, 0);
    send_word(ACT_SAMPLE, -400, 0);
    send_word(ACT_SAMPLE, 800, 1000);
    send_word(ACT_SAMPLE, -401, 500);
    send_word(ACT_SAMPLE, 801, 500);
    send_word(ACT_SAMPLE, 100, -1);
    send_word(ACT_SAMPLE, 100, 1001);
    send_word(ACT_SAMPLE, -2048, -2048);
    send_word(ACT_SAMPLE, 2047, 2047);
    send_word(ACT_SAMPLE, 300, 800);
    send_word(ACT_SAMPLE, 301, 500);
    send_tick();
    send_word(ACT_SAMPLE, 200, 801);
  endtask

  task automatic test_ramp_sequence();
    write_all(300, 800, 1, 2, 200);
    send_word(ACT_SAMPLE, 301, 0);
    send_tick();
    send_tick();
    send_tick();
    send_tick();
    send_word(ACT_SAMPLE, 900, 0);
    send_tick();
    send_tick();
  endtask

  // zero interval/hold behave like one; zero step never advances the ramp
  task automatic test_zero_registers();
    write_all(300, 800, 0, 0, 0);
    send_word(ACT_SAMPLE, 0, 900);
    send_tick();
    send_tick();
    write_all(300, 800, 0, 0, 255);
    send_tick();
    send_tick();
    send_tick();
  endtask

  task automatic test_random_phase(input int snd_pct, input int rcv_pct, input int n,
                                   input int t, input int h, input int iv, input int hd,
                                   input int inc);
    write_all(t, h, iv, hd, inc);
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (n / 2) send_random_word();
    write_all($urandom_range(1200) - 400, $urandom_range(1000), $urandom_range(6, 1),
              $urandom_range(40, 1), $urandom_range(255, 1));
    repeat (n - n / 2) send_random_word();
  endtask

  task automatic test_fill_stall();
    write_all(100, 500, 2, 10, 60);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_left = 80;
    repeat (40) send_random_word();
    settle();
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.action = ACT_SAMPLE;
    req_ch.temperature = '0;
    req_ch.humidity = '0;
    lim_temp = TEMP_LIMIT_RST;
    lim_hum = HUM_LIMIT_RST;
    ramp_iv = INTERVAL_RST;
    hold_len = HOLD_RST;
    duty_step = INCR_RST;
    alarm_act = 1'b0;
    alarm_hold = 1'b0;
    duty_lvl = 0;
    ticks = 0;
    last_temp = 0;
    last_hum = 0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    test_thresholds();
    test_ramp_sequence();
    test_zero_registers();
    test_random_phase(14, 80, 280, -400, 0, 1, 1, 255);
    test_random_phase(80, 14, 280, 800, 1000, 1023, 65535, 1);
    test_random_phase(0, 0, 250, 150, 500, 0, 0, 60);
    test_fill_stall();
    settle();

    $display("sent %0d words, checked %0d results, %0d alarm starts, %0d register writes",
             words_sent, words_checked, alarm_starts, reg_writes);
    $display("stimulus covered range limits, ramp/hold/off, zero registers and stalls");
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout after %0d words", words_sent);
    $display("tb_top failed");
    $finish;
  end

endmodule
